[hw/rtl/rbr_pkg.sv]
`default_nettype none
package rbr_pkg;

	typedef enum logic [2:0] {
		PH_COUNT     = 3'd0,
		PH_NAME_LEN  = 3'd1,
		PH_NAME_SKIP = 3'd2,
		PH_TYPE_LEN  = 3'd3,
		PH_TYPE_BODY = 3'd4,
		PH_VALUES    = 3'd5,
		PH_REJECTED  = 3'd6
	} phase_t;

	typedef enum logic [1:0] {
		ST_VALUE  = 2'd0,
		ST_REJECT = 2'd1,
		ST_END    = 2'd2
	} status_t;

	typedef struct packed {
		logic [63:0] value;
		status_t     status;
		logic        last;
	} result_t;

	localparam int unsigned LEB_MAX_BYTES = 10;
	localparam int unsigned TYPE_LEN_REQ  = 6;

	// expected type string, one character per index
	function automatic logic [7:0] type_char(input logic [2:0] idx);
		logic [7:0] c;
		case (idx)
			3'd0:    c = 8'h55;
			3'd1:    c = 8'h49;
			3'd2:    c = 8'h6E;
			3'd3:    c = 8'h74;
			3'd4:    c = 8'h36;
			3'd5:    c = 8'h34;
			default: c = 8'h00;
		endcase
		return c;
	endfunction

endpackage
`default_nettype wire

[hw/rtl/rbr_parser.sv]
`default_nettype none
module rbr_parser (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             accept,
	input  wire logic [7:0]       data_byte,
	input  wire logic             end_of_stream,
	output logic                  push,
	output rbr_pkg::result_t      result
);

	rbr_pkg::phase_t phase_q, phase_d, phase_upd;
	logic [63:0] acc_q, acc_d;
	logic [3:0]  vidx_q, vidx_d;
	logic [63:0] remain_q, remain_d;
	logic        tmatch_q, tmatch_d;
	logic [2:0]  tidx_q, tidx_d;
	logic [2:0]  vbidx_q, vbidx_d;
	logic [55:0] asm_q, asm_d;

	logic        is_varint;
	logic [5:0]  shamt;
	logic [63:0] acc_sum;
	logic        cont;
	logic        leb_over;
	logic        varint_done;
	logic [63:0] remain_dec;
	logic        tmatch_next;
	logic        value_emit;
	logic        fault;

	// byte decode shared by next-state and output logic
	always_comb begin
		is_varint   = (phase_q == rbr_pkg::PH_COUNT) || (phase_q == rbr_pkg::PH_NAME_LEN) ||
		              (phase_q == rbr_pkg::PH_TYPE_LEN);
		shamt       = 6'(7 * vidx_q);
		acc_sum     = acc_q | ({57'd0, data_byte[6:0]} << shamt);
		cont        = data_byte[7];
		leb_over    = cont && (vidx_q == 4'(rbr_pkg::LEB_MAX_BYTES - 1));
		varint_done = is_varint && !cont;
		remain_dec  = remain_q - 64'd1;
		tmatch_next = tmatch_q && !((tidx_q < 3'(rbr_pkg::TYPE_LEN_REQ)) &&
		              (data_byte != rbr_pkg::type_char(tidx_q)));
		value_emit  = (phase_q == rbr_pkg::PH_VALUES) && (vbidx_q == 3'd7);
		fault       = (is_varint && leb_over) ||
		              (varint_done && (phase_q == rbr_pkg::PH_COUNT) && (acc_sum != 64'd1)) ||
		              (varint_done && (phase_q == rbr_pkg::PH_TYPE_LEN) && (acc_sum == 64'd0)) ||
		              ((phase_q == rbr_pkg::PH_TYPE_BODY) && (remain_dec == 64'd0) &&
		               !tmatch_next);
	end

	// next state
	always_comb begin
		phase_d  = phase_q;
		acc_d    = acc_q;
		vidx_d   = vidx_q;
		remain_d = remain_q;
		tmatch_d = tmatch_q;
		tidx_d   = tidx_q;
		vbidx_d  = vbidx_q;
		asm_d    = asm_q;
		case (phase_q)
			rbr_pkg::PH_COUNT, rbr_pkg::PH_NAME_LEN, rbr_pkg::PH_TYPE_LEN: begin
				acc_d = acc_sum;
				if (cont) begin
					if (!leb_over) vidx_d = vidx_q + 4'd1;
				end else begin
					acc_d  = '0;
					vidx_d = '0;
					if (phase_q == rbr_pkg::PH_COUNT) begin
						if (acc_sum == 64'd1) phase_d = rbr_pkg::PH_NAME_LEN;
					end else if (phase_q == rbr_pkg::PH_NAME_LEN) begin
						remain_d = acc_sum;
						phase_d  = (acc_sum != 64'd0) ? rbr_pkg::PH_NAME_SKIP
						                              : rbr_pkg::PH_TYPE_LEN;
					end else begin
						remain_d = acc_sum;
						tmatch_d = (acc_sum == 64'(rbr_pkg::TYPE_LEN_REQ));
						tidx_d   = '0;
						if (acc_sum != 64'd0) phase_d = rbr_pkg::PH_TYPE_BODY;
					end
				end
			end
			rbr_pkg::PH_NAME_SKIP: begin
				remain_d = remain_dec;
				if (remain_dec == 64'd0) phase_d = rbr_pkg::PH_TYPE_LEN;
			end
			rbr_pkg::PH_TYPE_BODY: begin
				tmatch_d = tmatch_next;
				if (tidx_q != 3'd7) tidx_d = tidx_q + 3'd1;
				remain_d = remain_dec;
				if ((remain_dec == 64'd0) && tmatch_next) phase_d = rbr_pkg::PH_VALUES;
			end
			rbr_pkg::PH_VALUES: begin
				if (vbidx_q != 3'd7) begin
					asm_d   = asm_q | ({48'd0, data_byte} << {vbidx_q, 3'b000});
					vbidx_d = vbidx_q + 3'd1;
				end else begin
					asm_d   = '0;
					vbidx_d = '0;
				end
			end
			default: begin
			end
		endcase
		if (fault) phase_d = rbr_pkg::PH_REJECTED;
		phase_upd = phase_d;
		// end of stream rearms the parser
		if (end_of_stream) begin
			phase_d  = rbr_pkg::PH_COUNT;
			acc_d    = '0;
			vidx_d   = '0;
			remain_d = '0;
			tmatch_d = 1'b1;
			tidx_d   = '0;
			vbidx_d  = '0;
			asm_d    = '0;
		end
	end

	// outputs
	always_comb begin
		result.value  = '0;
		result.status = rbr_pkg::ST_VALUE;
		result.last   = end_of_stream;
		if (fault) begin
			result.status = rbr_pkg::ST_REJECT;
		end else if (value_emit) begin
			result.value = {data_byte, asm_q};
		end else if ((phase_upd == rbr_pkg::PH_VALUES) || (phase_upd == rbr_pkg::PH_REJECTED)) begin
			result.status = rbr_pkg::ST_END;
		end else begin
			result.status = rbr_pkg::ST_REJECT;
		end
		push = accept && (fault || value_emit || end_of_stream);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= rbr_pkg::PH_COUNT;
			acc_q    <= '0;
			vidx_q   <= '0;
			remain_q <= '0;
			tmatch_q <= 1'b1;
			tidx_q   <= '0;
			vbidx_q  <= '0;
			asm_q    <= '0;
		end else if (accept) begin
			phase_q  <= phase_d;
			acc_q    <= acc_d;
			vidx_q   <= vidx_d;
			remain_q <= remain_d;
			tmatch_q <= tmatch_d;
			tidx_q   <= tidx_d;
			vbidx_q  <= vbidx_d;
			asm_q    <= asm_d;
		end
	end

endmodule
`default_nettype wire

[hw/rtl/rbr_queue.sv]
`default_nettype none
module rbr_queue #(
	parameter int unsigned DEPTH = 4
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire rbr_pkg::result_t push_data,
	input  wire logic             pop,
	output logic                  full,
	output logic                  empty,
	output rbr_pkg::result_t      head
);

	localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);

	rbr_pkg::result_t entry_q [DEPTH];
	logic [PW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CW-1:0] count_q;

	assign full  = (count_q == CW'(DEPTH));
	assign empty = (count_q == '0);
	assign head  = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) entry_q[wr_ptr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			if (pop)  rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			if (push && !pop)      count_q <= count_q + CW'(1);
			else if (pop && !push) count_q <= count_q - CW'(1);
		end
	end

endmodule
`default_nettype wire

[hw/rtl/rbr_out_stage.sv]
`default_nettype none
module rbr_out_stage (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             head_valid,
	input  wire rbr_pkg::result_t head,
	output logic                  pop,
	output logic                  out_valid,
	input  wire logic             out_ready,
	output logic [63:0]           column_value,
	output logic [1:0]            status,
	output logic                  last
);

	logic             valid_q;
	rbr_pkg::result_t res_q;

	// refill whenever the register is empty or its transaction completes
	assign pop = head_valid && (!valid_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (pop) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) res_q <= head;
	end

	assign out_valid    = valid_q;
	assign column_value = res_q.value;
	assign status       = res_q.status;
	assign last         = res_q.last;

endmodule
`default_nettype wire

[hw/rtl/rowbinary_uint64_column_reader.sv]
// path: a result is queued as its byte is taken, then moves to the output register
// throughput: one byte per cycle; in_ready falls only when the result queue is full,
// which happens only while the output side holds off
// reset: arst_n clears the header parser to the column count phase and empties the queue
// and output register at once
`default_nettype none
module rowbinary_uint64_column_reader #(
	parameter int unsigned QUEUE_DEPTH = 4
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [7:0]  data_byte,
	input  wire logic        end_of_stream,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [63:0]      column_value,
	output logic [1:0]       status,
	output logic             last
);

	logic             accept;
	logic             push;
	logic             pop;
	logic             full;
	logic             empty;
	rbr_pkg::result_t push_data;
	rbr_pkg::result_t head;

	assign in_ready = !full;
	assign accept   = in_valid && in_ready;

	rbr_parser u_parser (
		.clk           (clk),
		.arst_n        (arst_n),
		.accept        (accept),
		.data_byte     (data_byte),
		.end_of_stream (end_of_stream),
		.push          (push),
		.result        (push_data)
	);

	rbr_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.full      (full),
		.empty     (empty),
		.head      (head)
	);

	rbr_out_stage u_out (
		.clk          (clk),
		.arst_n       (arst_n),
		.head_valid   (!empty),
		.head         (head),
		.pop          (pop),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.column_value (column_value),
		.status       (status),
		.last         (last)
	);

endmodule
`default_nettype wire

[hw/rtl/rbr_checker.sv]
`default_nettype none
module rbr_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic [63:0] column_value,
	input wire logic [1:0]  status,
	input wire logic        last
);

	// only value results carry data
	a_zero_unless_value: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status != rbr_pkg::ST_VALUE) |-> column_value == 64'd0)
		else $error("non-value result carries data");

	// end-of-stream status only comes from the closing transaction
	a_end_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == rbr_pkg::ST_END) |-> last)
		else $error("end status without last");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (status == rbr_pkg::ST_VALUE) || (status == rbr_pkg::ST_REJECT) ||
		              (status == rbr_pkg::ST_END))
		else $error("undefined status code");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(column_value) && $stable(status) &&
		                            $stable(last))
		else $error("stalled result changed");

endmodule

bind rowbinary_uint64_column_reader rbr_checker u_rbr_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.out_valid    (out_valid),
	.out_ready    (out_ready),
	.column_value (column_value),
	.status       (status),
	.last         (last)
);
`default_nettype wire
